>>> hdl/ahac_pkg.sv
package ahac_pkg;

	localparam int ADDR_W  = 64;
	localparam int PORT_W  = 16;
	localparam int TIME_W  = 32;
	localparam int LIMIT_W = 9;
	localparam int REM_W   = 9;
	localparam int CFG_W   = 32;

	localparam logic CFG_MAX_AGE     = 1'b0;
	localparam logic CFG_MAX_ENTRIES = 1'b1;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	localparam logic [TIME_W-1:0]  MAX_AGE_RESET     = 32'd86400;
	localparam logic [LIMIT_W-1:0] MAX_ENTRIES_RESET = 9'd256;

	// One stored entry as it moves along the row of cells.
	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] upper;
		logic [ADDR_W-1:0] lower;
		logic [PORT_W-1:0] port;
		logic [TIME_W-1:0] seen;
	} entry_t;

	// Per-cell command from the sequencer.
	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

	// An entry is stale when it was seen in the future or too long ago.
	function automatic logic is_expired(input logic [TIME_W-1:0] seen,
			input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] max_age);
		logic [TIME_W:0] age;
		begin
			age = {1'b0, now} - {1'b0, seen};
			is_expired = age[TIME_W] || (age[TIME_W-1:0] > max_age);
		end
	endfunction

endpackage

>>> hdl/ahac_cell.sv
module ahac_cell
	import ahac_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctl_t  ctl,
	input  entry_t     upper_nb,
	input  entry_t     new_entry,
	output entry_t     entry,
	output logic       match
);

	logic              valid_q;
	logic [ADDR_W-1:0] upper_q;
	logic [ADDR_W-1:0] lower_q;
	logic [PORT_W-1:0] port_q;
	logic [TIME_W-1:0] seen_q;

	// Shifting takes the younger neighbour's entry; loading takes the new key.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= upper_nb.valid;
		end else if (ctl.load) begin
			valid_q <= new_entry.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			upper_q <= upper_nb.upper;
			lower_q <= upper_nb.lower;
			port_q  <= upper_nb.port;
			seen_q  <= upper_nb.seen;
		end else if (ctl.load) begin
			upper_q <= new_entry.upper;
			lower_q <= new_entry.lower;
			port_q  <= new_entry.port;
			seen_q  <= new_entry.seen;
		end
	end

	assign entry = {valid_q, upper_q, lower_q, port_q, seen_q};
	assign match = valid_q && (upper_q == new_entry.upper)
		&& (lower_q == new_entry.lower) && (port_q == new_entry.port);

endmodule

>>> hdl/aging_host_address_cache.sv
// Aging host address cache.
// Request words arrive on the input channel (in_valid, in_stall) and carry a
// mode, a 128-bit address, a port and the current time. Each request gives
// exactly one result word on the output channel (out_valid, out_stall).
// One request is worked on at a time: in_stall is high from acceptance until
// the result word has been taken. A rejected request (zero port or zero
// address) goes straight to its result. A lookup searches the cells and
// removes a stale match. An insert searches, removes any old copy of its key,
// appends the new entry, evicts the oldest entry one per cycle while the
// count exceeds the limit, then removes the head entry if it has expired.
// While the receiver holds out_stall high the result word is kept and no new
// request is taken. Reset empties the store at once by clearing every cell's
// valid bit and restores the register defaults. Registers are written through
// cfg_we, cfg_idx and cfg_wdata; the user must write them only while the
// block is idle, as the block itself does not enforce this.
module aging_host_address_cache
	import ahac_pkg::*;
#(
	parameter int CAPACITY = 256
)
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_idx,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              mode,
	input  logic [ADDR_W-1:0] addr_upper,
	input  logic [ADDR_W-1:0] addr_lower,
	input  logic [PORT_W-1:0] port,
	input  logic [TIME_W-1:0] now,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              accepted,
	output logic              hit,
	output logic [TIME_W-1:0] last_seen,
	output logic [REM_W-1:0]  removed_count
);

	// One spare cell holds a new key before the limit evicts the oldest.
	localparam int N  = CAPACITY + 1;
	localparam int PW = $clog2(N);
	localparam int CW = $clog2(N + 1);
	localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
	localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FIND  = 3'd1;
	localparam logic [2:0] S_MOD   = 3'd2;
	localparam logic [2:0] S_APP   = 3'd3;
	localparam logic [2:0] S_EVICT = 3'd4;
	localparam logic [2:0] S_HEAD  = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]         state_q;
	logic [TIME_W-1:0]  max_age_q;
	logic [LIMIT_W-1:0] max_entries_q;
	logic               mode_q;
	entry_t             req_q;
	logic [CW-1:0]      count_q;
	logic               hit_q;
	logic [PW-1:0]      pos_q;
	logic [TIME_W-1:0]  pos_seen_q;
	logic               res_hit_q;
	logic [TIME_W-1:0]  res_seen_q;
	logic               res_acc_q;
	logic [REM_W-1:0]   removed_q;

	entry_t             cell_entry [N];
	entry_t             cell_nb    [N];
	cell_ctl_t          cell_ctl   [N];
	logic [N-1:0]       cell_match;

	logic               remove;
	logic [PW-1:0]      rm_pos;
	logic               find_hit;
	logic [PW-1:0]      find_pos;
	logic [TIME_W-1:0]  find_seen;
	logic [LW-1:0]      limit;
	logic               in_take;
	logic               req_ok;
	logic               pos_stale;
	logic               head_stale;
	logic [REM_W-1:0]   removed_inc;

	assign in_take   = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign req_ok    = (port != '0) && ((addr_upper != '0) || (addr_lower != '0));
	assign limit     = (LW'(max_entries_q) < CAP_L) ? LW'(max_entries_q) : CAP_L;
	assign pos_stale  = is_expired(pos_seen_q, req_q.seen, max_age_q);
	assign head_stale = is_expired(cell_entry[0].seen, req_q.seen, max_age_q);
	assign removed_inc = (removed_q == '1) ? removed_q : removed_q + REM_W'(1);

	// Keys are unique, so at most one cell matches: OR the hits together.
	always_comb begin
		find_hit  = 1'b0;
		find_pos  = '0;
		find_seen = '0;
		for (int i = 0; i < N; i++) begin
			find_hit  = find_hit | cell_match[i];
			find_pos  = find_pos | (cell_match[i] ? PW'(i) : '0);
			find_seen = find_seen | (cell_match[i] ? cell_entry[i].seen : '0);
		end
	end

	// Removal closes the gap: every cell at or above the position shifts down.
	always_comb begin
		remove = 1'b0;
		rm_pos = '0;
		case (state_q)
			S_MOD: begin
				remove = hit_q && ((mode_q == MODE_INSERT) || pos_stale);
				rm_pos = pos_q;
			end
			S_EVICT: remove = (LW'(count_q) > limit);
			S_HEAD:  remove = (count_q != '0) && head_stale;
			default: remove = 1'b0;
		endcase
	end

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			if (g == N - 1) begin : g_top
				assign cell_nb[g] = '0;
			end else begin : g_mid
				assign cell_nb[g] = cell_entry[g+1];
			end
			always_comb begin
				cell_ctl[g].shift = remove && (PW'(g) >= rm_pos);
				if (g == 0) begin
					cell_ctl[g].load = (state_q == S_APP) && !cell_entry[0].valid;
				end else begin
					cell_ctl[g].load = (state_q == S_APP) && !cell_entry[g].valid
						&& cell_entry[g-1].valid;
				end
			end
			ahac_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (cell_ctl[g]),
				.upper_nb  (cell_nb[g]),
				.new_entry (req_q),
				.entry     (cell_entry[g]),
				.match     (cell_match[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q     <= MAX_AGE_RESET;
			max_entries_q <= MAX_ENTRIES_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_MAX_AGE:     max_age_q     <= cfg_wdata;
				CFG_MAX_ENTRIES: max_entries_q <= cfg_wdata[LIMIT_W-1:0];
				default:         max_age_q     <= max_age_q;
			endcase
		end
	end

	// Request sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE:  if (in_take) state_q <= req_ok ? S_FIND : S_DONE;
				S_FIND:  state_q <= S_MOD;
				S_MOD: begin
					if (remove) count_q <= count_q - CW'(1);
					state_q <= (mode_q == MODE_LOOKUP) ? S_DONE : S_APP;
				end
				S_APP: begin
					count_q <= count_q + CW'(1);
					state_q <= S_EVICT;
				end
				S_EVICT: begin
					if (remove) count_q <= count_q - CW'(1);
					else state_q <= S_HEAD;
				end
				S_HEAD: begin
					if (remove) count_q <= count_q - CW'(1);
					state_q <= S_DONE;
				end
				S_DONE:  if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mode_q      <= mode;
				req_q.valid <= 1'b1;
				req_q.upper <= addr_upper;
				req_q.lower <= addr_lower;
				req_q.port  <= port;
				req_q.seen  <= now;
				res_acc_q   <= req_ok;
				res_hit_q   <= 1'b0;
				res_seen_q  <= '0;
				removed_q   <= '0;
			end
			S_FIND: begin
				hit_q      <= find_hit;
				pos_q      <= find_pos;
				pos_seen_q <= find_seen;
			end
			S_MOD: begin
				if (mode_q == MODE_INSERT) begin
					res_hit_q <= hit_q;
				end else if (hit_q && !pos_stale) begin
					res_hit_q  <= 1'b1;
					res_seen_q <= pos_seen_q;
				end else if (remove) begin
					removed_q <= removed_inc;
				end
			end
			S_EVICT, S_HEAD: if (remove) removed_q <= removed_inc;
			default: mode_q <= mode_q;
		endcase
	end

	assign out_valid     = (state_q == S_DONE);
	assign accepted      = res_acc_q;
	assign hit           = res_hit_q;
	assign last_seen     = res_seen_q;
	assign removed_count = removed_q;

endmodule

>>> sim/ahac_checker.sv
module ahac_checker
	import ahac_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_idx,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              mode,
	input  logic [ADDR_W-1:0] addr_upper,
	input  logic [ADDR_W-1:0] addr_lower,
	input  logic [PORT_W-1:0] port,
	input  logic [TIME_W-1:0] now,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic              accepted,
	input  logic              hit,
	input  logic [TIME_W-1:0] last_seen,
	input  logic [REM_W-1:0]  removed_count,
	output int                fail_count,
	output int                pending,
	output int                words_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 256;

	typedef struct packed {
		logic              accepted;
		logic              hit;
		logic [TIME_W-1:0] last_seen;
		logic [REM_W-1:0]  removed;
	} verdict_t;

	// Shadow copy of the store, oldest entry at index 0.
	entry_t            shadow[$];
	logic [TIME_W-1:0] age_limit;
	logic [LIMIT_W-1:0] entry_limit;
	verdict_t          awaited[$];

	function automatic logic stale(logic [TIME_W-1:0] seen, logic [TIME_W-1:0] t);
		longint diff;
		diff = longint'(t) - longint'(seen);
		return diff < 0 || diff > longint'(age_limit);
	endfunction

	function automatic verdict_t serve_request(logic m, logic [ADDR_W-1:0] up,
			logic [ADDR_W-1:0] lo, logic [PORT_W-1:0] p, logic [TIME_W-1:0] t);
		verdict_t v;
		int pos;
		int lim;
		int drops;
		entry_t e;
		v = '0;
		pos = -1;
		if (p == 0 || (up == 0 && lo == 0))
			return v;
		v.accepted = 1'b1;
		foreach (shadow[i])
			if (pos < 0 && shadow[i].upper == up && shadow[i].lower == lo &&
					shadow[i].port == p)
				pos = i;
		if (m == MODE_LOOKUP) begin
			if (pos >= 0) begin
				if (!stale(shadow[pos].seen, t)) begin
					v.hit = 1'b1;
					v.last_seen = shadow[pos].seen;
				end else begin
					shadow.delete(pos);
					v.removed = REM_W'(1);
				end
			end
		end else begin
			lim = (entry_limit < SLOTS) ? entry_limit : SLOTS;
			drops = 0;
			if (pos >= 0) begin
				v.hit = 1'b1;
				shadow.delete(pos);
			end
			e = '{valid: 1'b1, upper: up, lower: lo, port: p, seen: t};
			shadow.push_back(e);
			while (shadow.size() > lim && drops < 512) begin
				void'(shadow.pop_front());
				drops++;
			end
			if (shadow.size() > 0 && stale(shadow[0].seen, t)) begin
				void'(shadow.pop_front());
				drops++;
			end
			v.removed = (drops > 511) ? 9'd511 : REM_W'(drops);
		end
		return v;
	endfunction

	verdict_t got;
	verdict_t want;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow.delete();
			awaited.delete();
			age_limit <= MAX_AGE_RESET;
			entry_limit <= MAX_ENTRIES_RESET;
			fail_count <= 0;
			words_checked <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == CFG_MAX_AGE)
					age_limit <= cfg_wdata[TIME_W-1:0];
				else
					entry_limit <= cfg_wdata[LIMIT_W-1:0];
			end
			if (in_valid && !in_stall)
				awaited.push_back(serve_request(mode, addr_upper, addr_lower, port, now));
			if (out_valid && !out_stall) begin
				got = '{accepted, hit, last_seen, removed_count};
				words_checked <= words_checked + 1;
				if (awaited.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result word %p", got);
					fail_count <= fail_count + 1;
				end else begin
					want = awaited.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display("result word wrong: expected %p, got %p", want, got);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= awaited.size();
		end
	end

endmodule

>>> sim/testbench.sv
// Top of the cache testbench. It drives request words and register writes,
// applies random idling on both channels and a long receiver hold-off, and
// leaves all prediction and comparison to the checker beside the block.
module testbench
	import ahac_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_idx;
	logic [CFG_W-1:0]  cfg_wdata;
	logic              in_valid;
	logic              in_stall;
	logic              mode;
	logic [ADDR_W-1:0] addr_upper;
	logic [ADDR_W-1:0] addr_lower;
	logic [PORT_W-1:0] port;
	logic [TIME_W-1:0] now;
	logic              out_valid;
	logic              out_stall;
	logic              accepted;
	logic              hit;
	logic [TIME_W-1:0] last_seen;
	logic [REM_W-1:0]  removed_count;
	int                fail_count;
	int                pending;
	int                words_checked;

	int  cycle_count = 0;
	bit  calm;          // when set, neither side idles
	bit  hold_off;      // long receiver stall requested
	int  words_sent;

	// A small pool of keys, so that lookups and refreshes find known entries.
	logic [ADDR_W-1:0] key_up[16];
	logic [ADDR_W-1:0] key_lo[16];
	logic [PORT_W-1:0] key_port[16];
	logic [TIME_W-1:0] clock_now;

	aging_host_address_cache dut (.*);

	ahac_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Overall time limit: a generous bound on the slowest correct run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 900000) begin
			$display("aging_host_address_cache: mismatch");
			$finish;
		end
	end

	// The receiver stalls at random, not at all while calm, and for a long
	// counted stretch once a hold-off is asked for.
	initial begin
		int n;
		bit held;
		held = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off && !held) begin
				out_stall <= 1'b1;
				for (n = 0; n < 300; n++)
					@(posedge clk);
				held = 1'b1;
			end
			out_stall <= !calm && ($urandom_range(99) < 19);
		end
	end

	// Offer one request word and wait for it to be taken. The sender may
	// first idle at random.
	task automatic offer(logic m, logic [ADDR_W-1:0] up, logic [ADDR_W-1:0] lo,
			logic [PORT_W-1:0] p, logic [TIME_W-1:0] t);
		while (!calm && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		addr_upper <= up;
		addr_lower <= lo;
		port <= p;
		now <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
	endtask

	// Let every result arrive, then let the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// A request from the key pool, mostly well formed, with time drifting
	// forward and now and then stepping back or jumping to a random value.
	task automatic pool_request();
		int k;
		logic [ADDR_W-1:0] up;
		logic [ADDR_W-1:0] lo;
		logic [PORT_W-1:0] p;
		k = $urandom_range(15);
		up = key_up[k];
		lo = key_lo[k];
		p = key_port[k];
		case ($urandom_range(19))
			0: p = '0;
			1: begin up = '0; lo = '0; end
			2: begin
				up = {$urandom, $urandom};
				lo = {$urandom, $urandom};
				p = PORT_W'($urandom);
			end
			default: ;
		endcase
		case ($urandom_range(9))
			0: clock_now = clock_now - $urandom_range(50);
			1: clock_now = $urandom;
			default: clock_now = clock_now + $urandom_range(40);
		endcase
		offer(1'($urandom_range(1)), up, lo, p, clock_now);
	endtask

	initial begin
		int i;
		int phase;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_MAX_AGE;
		cfg_wdata = '0;
		in_valid = 1'b0;
		mode = MODE_INSERT;
		addr_upper = '0;
		addr_lower = '0;
		port = '0;
		now = '0;
		calm = 1'b0;
		hold_off = 1'b0;
		words_sent = 0;
		clock_now = 32'd1000;
		for (i = 0; i < 16; i++) begin
			key_up[i] = (i < 2) ? '0 : {$urandom, $urandom};
			key_lo[i] = (i == 1) ? '1 : {$urandom, $urandom};
			key_port[i] = (i == 3) ? '1 : PORT_W'($urandom_range(1, 65535));
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: rejected words, all-ones fields, a refresh, a lookup hit,
		// an expired lookup, a time in the future and a limit of zero.
		offer(MODE_INSERT, '0, '0, 16'd5, 32'd10);
		offer(MODE_LOOKUP, '1, '1, '0, 32'd10);
		offer(MODE_INSERT, '1, '1, '1, '1);
		offer(MODE_LOOKUP, '1, '1, '1, '1);
		offer(MODE_INSERT, '0, 64'd1, 16'd1, 32'd0);
		offer(MODE_INSERT, '0, 64'd1, 16'd1, 32'd100);
		offer(MODE_LOOKUP, '0, 64'd1, 16'd1, 32'd100);
		offer(MODE_LOOKUP, '0, 64'd1, 16'd1, 32'd200000);
		offer(MODE_LOOKUP, '1, '1, '1, 32'd5);
		offer(MODE_INSERT, 64'd7, '0, 16'd9, 32'd50);
		offer(MODE_INSERT, 64'd8, '0, 16'd9, 32'd40);
		drain();
		write_reg(CFG_MAX_AGE, '0);
		write_reg(CFG_MAX_ENTRIES, 32'd0);
		offer(MODE_INSERT, 64'd3, 64'd3, 16'd3, 32'd60);
		drain();
		write_reg(CFG_MAX_ENTRIES, 32'd511);
		write_reg(CFG_MAX_AGE, '1);
		offer(MODE_INSERT, 64'd3, 64'd3, 16'd3, 32'd0);
		offer(MODE_LOOKUP, 64'd3, 64'd3, 16'd3, '1);
		drain();

		// Fill the store to capacity with the limit beyond it, then lower
		// the limit sharply so one insert evicts many entries at once.
		calm = 1'b1;
		for (i = 0; i < 270; i++)
			offer(MODE_INSERT, 64'(i + 1), {$urandom, $urandom}, 16'd80, 32'(i));
		calm = 1'b0;
		drain();
		write_reg(CFG_MAX_ENTRIES, 32'd2);
		offer(MODE_INSERT, 64'd9, 64'd9, 16'd9, 32'd300);
		drain();

		// Random phases under varied registers, one with a long hold-off and
		// one with no idling at all.
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin write_reg(CFG_MAX_AGE, 32'd100); write_reg(CFG_MAX_ENTRIES, 32'd8); end
				1: begin write_reg(CFG_MAX_AGE, 32'd30); write_reg(CFG_MAX_ENTRIES, 32'd256); end
				2: begin write_reg(CFG_MAX_AGE, '1); write_reg(CFG_MAX_ENTRIES, 32'd4); end
				3: begin write_reg(CFG_MAX_AGE, 32'd0); write_reg(CFG_MAX_ENTRIES, 32'd1); end
				4: begin
					write_reg(CFG_MAX_AGE, $urandom_range(200));
					write_reg(CFG_MAX_ENTRIES, $urandom_range(511));
				end
				default: begin
					write_reg(CFG_MAX_AGE, 32'd86400);
					write_reg(CFG_MAX_ENTRIES, 32'd12);
				end
			endcase
			calm = (phase == 1);
			if (phase == 2)
				hold_off = 1'b1;
			for (i = 0; i < 100; i++)
				pool_request();
			calm = 1'b0;
			drain();
		end

		$display("Sent %0d request words, checked %0d result words, across", words_sent,
			words_checked);
		$display("rejected words, refreshes, expiry, eviction bursts and register extremes.");
		if (fail_count == 0)
			$display("aging_host_address_cache: match");
		else
			$display("aging_host_address_cache: mismatch");
		$finish;
	end

endmodule
